[sv/assert_macros.svh]
// assertion helpers used by the rtl datapath
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define ASSERT_ALWAYS(label, clk, rst, expr) \
  label: assert property (@(posedge clk) disable iff (rst) (expr)) \
    else $error("assertion failed");
`define ASSERT_NEXT(label, clk, rst, pre, post) \
  label: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) \
    else $error("assertion failed");
`else
`define ASSERT_ALWAYS(label, clk, rst, expr)
`define ASSERT_NEXT(label, clk, rst, pre, post)
`endif
`endif

[sv/psfl_pkg.sv]
`timescale 1ns / 1ps
package psfl_pkg;

  localparam int SLOT_COUNT = 1024;
  localparam int SLOT_W = 11;
  localparam int IDX_W = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;
  localparam logic [SLOT_W-1:0] SLOT_MAX = SLOT_W'(SLOT_COUNT);

  typedef enum logic [1:0] {
    ST_ALLOCATED = 2'd0,
    ST_EMPTY     = 2'd1,
    ST_RELEASED  = 2'd2,
    ST_IGNORED   = 2'd3
  } status_t;

  typedef enum logic {
    CMD_ALLOC   = 1'b0,
    CMD_RELEASE = 1'b1
  } command_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_EXEC,
    S_RESP
  } state_t;

  typedef struct packed {
    logic capture;
    logic exec;
  } dp_ctrl_t;

endpackage

[sv/psfl_ctrl.sv]
`timescale 1ns / 1ps
module psfl_ctrl
  import psfl_pkg::*;
(
  input  logic     clk,
  input  logic     rst,
  input  logic     in_valid,
  output logic     in_ready,
  output logic     out_valid,
  input  logic     out_ready,
  output dp_ctrl_t dp_ctrl
);

  state_t state;
  state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (in_valid) state_next = S_EXEC;
      end
      S_EXEC: begin
        state_next = S_RESP;
      end
      S_RESP: begin
        if (out_ready) state_next = in_valid ? S_EXEC : S_IDLE;
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_comb begin
    in_ready = 1'b0;
    out_valid = 1'b0;
    dp_ctrl.exec = 1'b0;
    unique case (state)
      S_IDLE: begin
        in_ready = 1'b1;
      end
      S_EXEC: begin
        dp_ctrl.exec = 1'b1;
      end
      S_RESP: begin
        out_valid = 1'b1;
        // a new beat may enter as the result leaves
        in_ready = out_ready;
      end
      default: begin
        in_ready = 1'b0;
      end
    endcase
    dp_ctrl.capture = in_valid && in_ready;
  end

endmodule

[sv/psfl_datapath.sv]
`timescale 1ns / 1ps
`include "assert_macros.svh"
module psfl_datapath
  import psfl_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  dp_ctrl_t          dp_ctrl,
  input  logic              command,
  input  logic [SLOT_W-1:0] slot_index,
  output logic [SLOT_W-1:0] granted_slot,
  output logic [1:0]        status,
  output logic [SLOT_W-1:0] slots_in_use
);

  logic [SLOT_W-1:0] stack_mem [SLOT_COUNT];
  logic              map_mem [SLOT_COUNT];

  logic [SLOT_W-1:0] free_count;
  logic [SLOT_W-1:0] in_use_count;
  // lowest stack depth reached since reset: positions below it still hold reset contents
  logic [SLOT_W-1:0] low_mark;

  logic              cmd_q;
  logic [SLOT_W-1:0] slot_q;
  logic [SLOT_W-1:0] stack_q;
  logic              map_q;

  logic [SLOT_W-1:0] free_count_next;
  logic [SLOT_W-1:0] in_use_count_next;
  logic [SLOT_W-1:0] low_mark_next;
  logic [SLOT_W-1:0] top_pos;
  logic [SLOT_W-1:0] slot_dec;
  logic [SLOT_W-1:0] grant;
  logic              pristine;
  logic              slot_free;
  logic              slot_ok;
  logic              stack_we;
  logic              map_we;
  logic              map_wdata;
  logic [IDX_W-1:0]  map_waddr;
  logic [SLOT_W-1:0] top_pos_rd;
  logic [SLOT_W-1:0] slot_dec_rd;
  status_t           status_calc;

  assign top_pos_rd  = free_count - SLOT_W'(1);
  assign slot_dec_rd = slot_index - SLOT_W'(1);

  always_ff @(posedge clk) begin
    if (dp_ctrl.capture) begin
      cmd_q   <= command;
      slot_q  <= slot_index;
      stack_q <= stack_mem[top_pos_rd[IDX_W-1:0]];
      map_q   <= map_mem[slot_dec_rd[IDX_W-1:0]];
    end
  end

  always_comb begin
    top_pos = free_count - SLOT_W'(1);
    slot_dec = slot_q - SLOT_W'(1);
    pristine = top_pos < low_mark;
    grant = pristine ? (SLOT_MAX - top_pos) : stack_q;
    // slots above this bound were never granted, so they are still free
    slot_free = (slot_q > (SLOT_MAX - low_mark)) ? 1'b1 : map_q;
    slot_ok = (slot_q != '0) && (slot_q <= SLOT_MAX) && !slot_free &&
              (free_count < SLOT_MAX);

    free_count_next = free_count;
    in_use_count_next = in_use_count;
    low_mark_next = low_mark;
    stack_we = 1'b0;
    map_we = 1'b0;
    map_wdata = 1'b0;
    map_waddr = slot_dec[IDX_W-1:0];
    status_calc = ST_IGNORED;

    if (cmd_q == CMD_ALLOC) begin
      if (free_count == '0) begin
        status_calc = ST_EMPTY;
      end else begin
        status_calc = ST_ALLOCATED;
        free_count_next = top_pos;
        in_use_count_next = in_use_count + SLOT_W'(1);
        if (pristine) low_mark_next = top_pos;
        map_we = 1'b1;
        map_wdata = 1'b0;
        map_waddr = IDX_W'(grant - SLOT_W'(1));
      end
    end else if (slot_ok) begin
      status_calc = ST_RELEASED;
      free_count_next = free_count + SLOT_W'(1);
      if (in_use_count != '0) in_use_count_next = in_use_count - SLOT_W'(1);
      stack_we = 1'b1;
      map_we = 1'b1;
      map_wdata = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (dp_ctrl.exec && stack_we) begin
      stack_mem[free_count[IDX_W-1:0]] <= slot_q;
    end
    if (dp_ctrl.exec && map_we) begin
      map_mem[map_waddr] <= map_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      free_count   <= SLOT_MAX;
      in_use_count <= '0;
      low_mark     <= SLOT_MAX;
    end else if (dp_ctrl.exec) begin
      free_count   <= free_count_next;
      in_use_count <= in_use_count_next;
      low_mark     <= low_mark_next;
    end
  end

  always_ff @(posedge clk) begin
    if (dp_ctrl.exec) begin
      granted_slot <= (status_calc == ST_ALLOCATED) ? grant : '0;
      status       <= status_calc;
      slots_in_use <= in_use_count_next;
    end
  end

  `ASSERT_ALWAYS(a_count_sum, clk, rst,
    ({1'b0, free_count} + {1'b0, in_use_count}) == (SLOT_W + 1)'(SLOT_COUNT))
  `ASSERT_ALWAYS(a_low_mark, clk, rst, low_mark <= free_count)
  `ASSERT_NEXT(a_pop, clk, rst,
    dp_ctrl.exec && (cmd_q == CMD_ALLOC) && (free_count != '0),
    free_count == $past(free_count) - SLOT_W'(1))

endmodule

[sv/packet_slot_free_list_top.sv]
`timescale 1ns / 1ps
// packet slot allocator: hands out slots 1..SLOT_COUNT from a lifo free list
// input channel: in_valid/in_ready with command (0 allocate, 1 release) and
//   slot_index (the slot to give back; ignored for allocate)
// output channel: out_valid/out_ready with granted_slot, status and slots_in_use,
//   exactly one result beat per request beat
// a request is captured when accepted, processed in the execute state, and its result
//   is registered and offered in the response state
// a new request is not taken while one is executing; the stack and slot map memories
//   are read in the accept cycle and written in the following execute cycle
// a released slot goes on top of the stack and is the next one granted
// after reset all slots are free with slot 1 granted first; no clearing pass
//   runs, a low-water mark on the stack stands in for the untouched reset contents
// when the receiver stalls the result holds in the output register and no new
//   request is taken until it leaves; a new request may enter in the same cycle
module packet_slot_free_list_top
  import psfl_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic              command,
  input  logic [SLOT_W-1:0] slot_index,
  output logic              out_valid,
  input  logic              out_ready,
  output logic [SLOT_W-1:0] granted_slot,
  output logic [1:0]        status,
  output logic [SLOT_W-1:0] slots_in_use
);

  dp_ctrl_t dp_ctrl;

  psfl_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .dp_ctrl   (dp_ctrl)
  );

  psfl_datapath u_datapath (
    .clk          (clk),
    .rst          (rst),
    .dp_ctrl      (dp_ctrl),
    .command      (command),
    .slot_index   (slot_index),
    .granted_slot (granted_slot),
    .status       (status),
    .slots_in_use (slots_in_use)
  );

endmodule

[tb/tb.sv]
`timescale 1ns / 1ps
module tb;
  import psfl_pkg::*;

  localparam int LONG_HOLD_CYCLES = 64;
  localparam int SLOT_IDX_MAX = (1 << SLOT_W) - 1;

  typedef struct {
    logic [SLOT_W-1:0] granted;
    status_t           status;
    logic [SLOT_W-1:0] in_use;
  } slot_reply_t;

  logic              clk = 1'b0;
  logic              rst;
  logic              in_valid;
  logic              in_ready;
  logic              command;
  logic [SLOT_W-1:0] slot_index;
  logic              out_valid;
  logic              out_ready;
  logic [SLOT_W-1:0] granted_slot;
  logic [1:0]        status;
  logic [SLOT_W-1:0] slots_in_use;

  // shadow copy of the allocator state
  logic [SLOT_W-1:0] free_stack [SLOT_COUNT];
  bit                slot_free [SLOT_COUNT+1];
  int                free_depth;
  int                in_use;
  logic [SLOT_W-1:0] slots_held [$];
  slot_reply_t       slot_replies_due [$];

  int mismatches = 0;
  int pool_empty_replies = 0;
  bit idle_on = 1'b1;
  bit hold_sink = 1'b0;

  packet_slot_free_list_top u_dut (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .command      (command),
    .slot_index   (slot_index),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .granted_slot (granted_slot),
    .status       (status),
    .slots_in_use (slots_in_use)
  );

  always #5 clk = ~clk;

  task automatic report_mismatch(input string what, input int want, input int got);
    $display("%0t: %s: expected %0d, got %0d", $realtime, what, want, got);
    mismatches++;
  endtask

  function automatic void reset_slot_model();
    for (int i = 0; i < SLOT_COUNT; i++) begin
      free_stack[i] = SLOT_W'(SLOT_COUNT - i);
      slot_free[i + 1] = 1'b1;
    end
    free_depth = SLOT_COUNT;
    in_use = 0;
  endfunction

  // pop on allocate, push on a valid release; one reply per request
  function automatic void apply_slot_request(input command_t cmd,
                                             input logic [SLOT_W-1:0] idx);
    slot_reply_t r;
    r.granted = '0;
    if (cmd == CMD_ALLOC) begin
      if (free_depth == 0) begin
        r.status = ST_EMPTY;
        pool_empty_replies++;
      end else begin
        free_depth--;
        r.granted = free_stack[free_depth];
        slot_free[r.granted] = 1'b0;
        slots_held.push_back(r.granted);
        in_use++;
        r.status = ST_ALLOCATED;
      end
    end else if (idx >= 1 && idx <= SLOT_COUNT && !slot_free[idx]) begin
      free_stack[free_depth] = idx;
      free_depth++;
      slot_free[idx] = 1'b1;
      if (in_use > 0) in_use--;
      for (int i = 0; i < slots_held.size(); i++) begin
        if (slots_held[i] == idx) begin
          slots_held.delete(i);
          break;
        end
      end
      r.status = ST_RELEASED;
    end else begin
      r.status = ST_IGNORED;
    end
    r.in_use = SLOT_W'(in_use);
    slot_replies_due.push_back(r);
  endfunction

  task automatic send_request(input command_t cmd, input logic [SLOT_W-1:0] idx);
    if (idle_on && $urandom_range(0, 3) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 14)) @(posedge clk);
    end
    in_valid   <= 1'b1;
    command    <= cmd;
    slot_index <= idx;
    do @(posedge clk); while (!in_ready);
    apply_slot_request(cmd, idx);
  endtask

  // mostly well-formed traffic: releases other than the noise ones pick a slot that is really held
  task automatic send_weighted(input int alloc_pct, input int noise_pct);
    int roll;
    logic [SLOT_W-1:0] idx;
    roll = $urandom_range(0, 99);
    idx = SLOT_W'($urandom_range(0, SLOT_IDX_MAX));
    if (roll < alloc_pct) begin
      send_request(CMD_ALLOC, idx);
    end else if (roll < alloc_pct + noise_pct || slots_held.size() == 0) begin
      case ($urandom_range(0, 2))
        0: idx = '0;
        1: idx = SLOT_W'($urandom_range(SLOT_COUNT + 1, SLOT_IDX_MAX));
        default: idx = SLOT_W'($urandom_range(1, SLOT_COUNT));
      endcase
      send_request(CMD_RELEASE, idx);
    end else begin
      send_request(CMD_RELEASE, slots_held[$urandom_range(0, slots_held.size() - 1)]);
    end
  endtask

  task automatic test_directed();
    send_request(CMD_ALLOC, '0);
    send_request(CMD_ALLOC, SLOT_W'(SLOT_IDX_MAX));
    send_request(CMD_ALLOC, 11'd7);
    send_request(CMD_RELEASE, 11'd2);
    send_request(CMD_ALLOC, '0);                       // lifo: slot 2 comes back
    send_request(CMD_RELEASE, '0);                     // slot zero is never valid
    send_request(CMD_RELEASE, SLOT_W'(SLOT_COUNT + 1));
    send_request(CMD_RELEASE, SLOT_W'(SLOT_IDX_MAX));
    send_request(CMD_RELEASE, SLOT_W'(SLOT_COUNT));    // in range but still free
    send_request(CMD_RELEASE, 11'd5);
    send_request(CMD_RELEASE, 11'd3);
    send_request(CMD_RELEASE, 11'd3);                  // double free
    send_request(CMD_RELEASE, 11'd1);
    send_request(CMD_ALLOC, 11'h555);
    send_request(CMD_ALLOC, 11'h2aa);
    send_request(CMD_RELEASE, 11'd1);
    send_request(CMD_RELEASE, 11'd2);
    send_request(CMD_RELEASE, 11'd3);
    send_request(CMD_ALLOC, '0);
    send_request(CMD_ALLOC, '0);
  endtask

  task automatic test_random_mix();
    for (int n = 0; n < 250; n++) send_weighted(50, 12);
  endtask

  // sink stops for a long stretch so the result register backs up into the input
  task automatic test_backpressure();
    hold_sink = 1'b1;
    for (int n = 0; n < 30; n++) send_weighted(50, 10);
  endtask

  task automatic test_pool_drain();
    int n;
    n = 0;
    while (pool_empty_replies < 6 && n < 1300) begin
      send_weighted(96, 1);
      n++;
    end
  endtask

  task automatic test_release_flood();
    idle_on = 1'b0;
    for (int n = 0; n < 400; n++) send_weighted(10, 5);
  endtask

  initial begin : ready_driver
    out_ready = 1'b0;
    @(posedge clk iff !rst);
    forever begin
      if (hold_sink) begin
        out_ready <= 1'b0;
        repeat (LONG_HOLD_CYCLES) @(posedge clk);
        hold_sink = 1'b0;
      end else if (idle_on && $urandom_range(0, 4) == 0) begin
        out_ready <= 1'b0;
        repeat ($urandom_range(1, 14)) @(posedge clk);
      end else begin
        out_ready <= 1'b1;
        @(posedge clk);
      end
    end
  end

  initial begin : reply_checker
    slot_reply_t want;
    forever begin
      @(posedge clk);
      if (!rst && out_valid && out_ready) begin
        if (slot_replies_due.size() == 0) begin
          report_mismatch("reply beat with no request pending", 0, int'(status));
        end else begin
          want = slot_replies_due.pop_front();
          if (granted_slot !== want.granted)
            report_mismatch("granted_slot", int'(want.granted), int'(granted_slot));
          if (status !== want.status)
            report_mismatch("status", int'(want.status), int'(status));
          if (slots_in_use !== want.in_use)
            report_mismatch("slots_in_use", int'(want.in_use), int'(slots_in_use));
        end
      end
    end
  end

  initial begin : watchdog
    #4_000_000;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

  initial begin : main
    int waited;
    rst = 1'b1;
    in_valid = 1'b0;
    command = CMD_ALLOC;
    slot_index = '0;
    reset_slot_model();
    repeat (5) @(posedge clk);
    rst <= 1'b0;

    test_directed();
    test_random_mix();
    test_backpressure();
    test_pool_drain();
    test_release_flood();

    in_valid <= 1'b0;
    waited = 0;
    while (slot_replies_due.size() != 0 && waited < 5000) begin
      @(posedge clk);
      waited++;
    end
    repeat (10) @(posedge clk);
    if (slot_replies_due.size() != 0)
      report_mismatch("replies never returned", 0, slot_replies_due.size());

    if (mismatches == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

[filelist.f]
+incdir+sv
sv/psfl_pkg.sv
sv/psfl_ctrl.sv
sv/psfl_datapath.sv
sv/packet_slot_free_list_top.sv
tb/tb.sv
